>>> rtl/linear_recurrence_matrix_power_mod_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tiling counter.
// Both macros expect a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_MOD_DEFINES_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_MOD_DEFINES_SVH

// Same-cycle implication.
`define LRMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lrmp_pkg.sv
// ---------------------------------------------------------------------------
// lrmp_pkg
// Constants, types and the control store of the 3-by-n tiling counter.
// ---------------------------------------------------------------------------
`default_nettype none

package lrmp_pkg;

  localparam int WIDTH_BITS_DEF = 31;

  localparam int RES_W   = 14;  // one residue mod 9973
  localparam int PROD_W  = 28;  // sum of two residue products
  localparam int RECIP_W = 15;
  localparam int QUO_W   = 15;
  localparam int REM_W   = 15;  // partial remainder, below twice the modulus

  typedef logic [RES_W-1:0] res_t;

  localparam res_t TILE_MOD      = 14'd9973;
  localparam res_t MOD_MINUS_ONE = 14'd9972;
  localparam res_t BASE_FOUR     = 14'd4;
  localparam res_t FINAL_C0      = 14'd3;
  localparam res_t FINAL_C1      = 14'd1;
  localparam res_t RES_ZERO      = 14'd0;
  localparam res_t RES_ONE       = 14'd1;

  // floor(2^28 / 9973); the estimated quotient is low by at most one.
  localparam logic [RECIP_W-1:0] MOD_RECIP = 15'd26916;

  typedef struct packed {
    res_t m00;
    res_t m01;
    res_t m10;
    res_t m11;
  } mat_t;

  localparam mat_t MAT_IDENT = '{m00: RES_ONE, m01: RES_ZERO, m10: RES_ZERO, m11: RES_ONE};
  localparam mat_t MAT_BASE_INIT = '{m00: BASE_FOUR, m01: MOD_MINUS_ONE,
                                     m10: RES_ONE, m11: RES_ZERO};

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_MUL,
    UOP_BR_TRIVIAL,
    UOP_BR_EXP_ZERO,
    UOP_BR_BIT_CLEAR,
    UOP_SHIFT,
    UOP_TRIVIAL,
    UOP_OUT
  } uop_t;

  typedef enum logic {MAT_ACC, MAT_BASE} mat_sel_t;
  typedef enum logic {RHS_BASE, RHS_FINAL} rhs_t;
  typedef enum logic [1:0] {DST_ACC, DST_BASE, DST_RES} dst_t;

  typedef struct packed {
    uop_t     op;
    mat_sel_t lhs;
    rhs_t     rhs;
    logic     row;
    logic     col;
    dst_t     dst;
    pc_t      target;
  } ucode_t;

  // Tag that follows one dot product down the reduction pipeline.
  typedef struct packed {
    logic       valid;
    dst_t       dst;
    logic [1:0] idx;
  } wb_tag_t;

  localparam pc_t PC_START   = 5'd0;
  localparam pc_t PC_LOOP    = 5'd1;
  localparam pc_t PC_SQUARE  = 5'd7;
  localparam pc_t PC_FINAL   = 5'd13;
  localparam pc_t PC_OUT     = 5'd17;
  localparam pc_t PC_TRIVIAL = 5'd18;

  function automatic ucode_t ctl_word(input uop_t op, input pc_t target);
    ucode_t w;
    w = '{op: op, lhs: MAT_ACC, rhs: RHS_BASE, row: 1'b0, col: 1'b0,
          dst: DST_ACC, target: target};
    return w;
  endfunction

  function automatic ucode_t mul_word(input mat_sel_t lhs, input rhs_t rhs, input logic row,
                                      input logic col, input dst_t dst);
    ucode_t w;
    w = '{op: UOP_MUL, lhs: lhs, rhs: rhs, row: row, col: col, dst: dst, target: PC_START};
    return w;
  endfunction

  // Control store. A product passes the s1, s2 and s3 registers before it
  // lands in its matrix, so the order below never reads an entry too early.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      5'd0:  w = ctl_word(UOP_BR_TRIVIAL, PC_TRIVIAL);
      5'd1:  w = ctl_word(UOP_BR_EXP_ZERO, PC_FINAL);
      5'd2:  w = ctl_word(UOP_BR_BIT_CLEAR, PC_SQUARE);
      5'd3:  w = mul_word(MAT_ACC, RHS_BASE, 1'b0, 1'b0, DST_ACC);
      5'd4:  w = mul_word(MAT_ACC, RHS_BASE, 1'b0, 1'b1, DST_ACC);
      5'd5:  w = mul_word(MAT_ACC, RHS_BASE, 1'b1, 1'b0, DST_ACC);
      5'd6:  w = mul_word(MAT_ACC, RHS_BASE, 1'b1, 1'b1, DST_ACC);
      5'd7:  w = mul_word(MAT_BASE, RHS_BASE, 1'b0, 1'b0, DST_BASE);
      5'd8:  w = mul_word(MAT_BASE, RHS_BASE, 1'b0, 1'b1, DST_BASE);
      5'd9:  w = mul_word(MAT_BASE, RHS_BASE, 1'b1, 1'b0, DST_BASE);
      5'd10: w = mul_word(MAT_BASE, RHS_BASE, 1'b1, 1'b1, DST_BASE);
      5'd11: w = ctl_word(UOP_SHIFT, PC_LOOP);
      5'd13: w = mul_word(MAT_ACC, RHS_FINAL, 1'b0, 1'b0, DST_RES);
      5'd17: w = ctl_word(UOP_OUT, PC_START);
      5'd18: w = ctl_word(UOP_TRIVIAL, PC_OUT);
      default: w = ctl_word(UOP_NOP, PC_START);
    endcase
    return w;
  endfunction

  function automatic mat_t mat_put(input mat_t m, input logic [1:0] idx, input res_t v);
    mat_t r;
    r = m;
    unique case (idx)
      2'd0: r.m00 = v;
      2'd1: r.m01 = v;
      2'd2: r.m10 = v;
      2'd3: r.m11 = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lrmp_stream_ifs.sv
// ---------------------------------------------------------------------------
// lrmp stream interfaces
// Valid/ready channels for the board width and for the tiling count.
// ---------------------------------------------------------------------------
`default_nettype none

interface lrmp_width_if
  import lrmp_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] board_width;

  modport source (output valid, output board_width, input ready);
  modport sink   (input valid, input board_width, output ready);
endinterface

interface lrmp_count_if
  import lrmp_pkg::*;
();
  logic valid;
  logic ready;
  res_t tiling_count;

  modport source (output valid, output tiling_count, input ready);
  modport sink   (input valid, input tiling_count, output ready);
endinterface

`default_nettype wire

>>> rtl/linear_recurrence_matrix_power_mod.sv
// Odd and zero widths take a short path that skips the matrix power; other
// widths run square-and-multiply over the bits of n/2-1, with every product
// passing through the shared dot-product unit.
// One item at a time: the next beat is taken the cycle after the result is
// registered, while that result may still wait at the output.
// Reset (synchronous, active low) idles the sequencer and empties the output.
`default_nettype none

`include "linear_recurrence_matrix_power_mod_defines.svh"

// ---------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod
// Counts tilings of a 3-by-n board mod 9973 by square-and-multiply of a 2x2
// matrix, run by a microcoded sequencer over one pipelined dot-product unit.
// ---------------------------------------------------------------------------
module linear_recurrence_matrix_power_mod
  import lrmp_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  lrmp_width_if.sink   in_stream,
  lrmp_count_if.source out_stream
);

  localparam int EXP_W = WIDTH_BITS - 1;

  logic                  busy_r, busy_nxt;
  pc_t                   pc_r, pc_nxt;
  logic [EXP_W-1:0]      e_r, e_nxt;
  logic                  odd_r, zero_r;
  mat_t                  acc_r, base_r;
  res_t                  res_r;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_data_r;

  logic                  in_fire;
  logic [WIDTH_BITS-1:0] n_in;
  ucode_t                ctrl;
  logic                  issue, triv_load, out_load;

  // Reduction pipeline.
  wb_tag_t               s1_tag_r, s2_tag_r, s3_tag_r, issue_tag;
  logic [PROD_W-1:0]     s1_sum_r, s2_sum_r, dot_sum;
  logic [QUO_W-1:0]      s2_quo_r;
  logic [REM_W-1:0]      s3_rem_r, rem_full;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  res_t                  rem_red;
  res_t                  x0, x1, y0, y1;
  mat_t                  lhs_mat;
  logic                  pipe_busy;

  assign n_in            = in_stream.board_width;
  assign in_stream.ready = !busy_r;
  assign in_fire         = in_stream.valid && !busy_r;

  assign out_stream.valid        = out_valid_r;
  assign out_stream.tiling_count = out_data_r;

  assign ctrl = ucode_rom(pc_r);

  assign pipe_busy = s1_tag_r.valid || s2_tag_r.valid || s3_tag_r.valid;

  // Sequencer.
  always_comb begin
    pc_nxt    = pc_r + pc_t'(1);
    busy_nxt  = busy_r;
    e_nxt     = e_r;
    issue     = 1'b0;
    triv_load = 1'b0;
    out_load  = 1'b0;
    if (!busy_r) begin
      pc_nxt = PC_START;
      if (in_fire) begin
        busy_nxt = 1'b1;
      end
    end else begin
      unique case (ctrl.op)
        UOP_NOP: begin
        end
        UOP_MUL: begin
          issue = 1'b1;
        end
        UOP_BR_TRIVIAL: begin
          if (odd_r || zero_r) pc_nxt = ctrl.target;
        end
        UOP_BR_EXP_ZERO: begin
          if (e_r == '0) pc_nxt = ctrl.target;
        end
        UOP_BR_BIT_CLEAR: begin
          if (!e_r[0]) pc_nxt = ctrl.target;
        end
        UOP_SHIFT: begin
          e_nxt  = e_r >> 1;
          pc_nxt = ctrl.target;
        end
        UOP_TRIVIAL: begin
          triv_load = 1'b1;
          pc_nxt    = ctrl.target;
        end
        UOP_OUT: begin
          if (!out_valid_r || out_stream.ready) begin
            out_load = 1'b1;
            busy_nxt = 1'b0;
            pc_nxt   = PC_START;
          end else begin
            pc_nxt = pc_r;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Dot product of one row of the left matrix with one column of the base,
  // or with the constant column (3, 1) for the final answer.
  always_comb begin
    lhs_mat = (ctrl.lhs == MAT_ACC) ? acc_r : base_r;
    x0 = ctrl.row ? lhs_mat.m10 : lhs_mat.m00;
    x1 = ctrl.row ? lhs_mat.m11 : lhs_mat.m01;
    if (ctrl.rhs == RHS_BASE) begin
      y0 = ctrl.col ? base_r.m01 : base_r.m00;
      y1 = ctrl.col ? base_r.m11 : base_r.m10;
    end else begin
      y0 = FINAL_C0;
      y1 = FINAL_C1;
    end
    dot_sum = (PROD_W'(x0) * PROD_W'(y0)) + (PROD_W'(x1) * PROD_W'(y1));
    issue_tag.valid = issue;
    issue_tag.dst   = ctrl.dst;
    issue_tag.idx   = {ctrl.row, ctrl.col};
  end

  assign recip_prod = (PROD_W+RECIP_W)'(s1_sum_r) * (PROD_W+RECIP_W)'(MOD_RECIP);
  assign rem_full   = REM_W'(s2_sum_r - (PROD_W'(s2_quo_r) * PROD_W'(TILE_MOD)));
  assign rem_red    = (s3_rem_r >= REM_W'(TILE_MOD)) ? RES_W'(s3_rem_r - REM_W'(TILE_MOD))
                                                     : RES_W'(s3_rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_START;
      out_valid_r <= 1'b0;
      s1_tag_r    <= '0;
      s2_tag_r    <= '0;
      s3_tag_r    <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      s1_tag_r    <= issue_tag;
      s2_tag_r    <= s1_tag_r;
      s3_tag_r    <= s2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sum_r <= dot_sum;
    s2_sum_r <= s1_sum_r;
    s2_quo_r <= recip_prod[PROD_W +: QUO_W];
    s3_rem_r <= rem_full;
    if (out_load) out_data_r <= res_r;
    if (in_fire) begin
      e_r    <= n_in[WIDTH_BITS-1:1] - EXP_W'(1);
      odd_r  <= n_in[0];
      zero_r <= (n_in == '0);
      acc_r  <= MAT_IDENT;
      base_r <= MAT_BASE_INIT;
    end else begin
      e_r <= e_nxt;
      if (triv_load) res_r <= odd_r ? RES_ZERO : RES_ONE;
      if (s3_tag_r.valid) begin
        unique case (s3_tag_r.dst)
          DST_ACC:  acc_r  <= mat_put(acc_r, s3_tag_r.idx, rem_red);
          DST_BASE: base_r <= mat_put(base_r, s3_tag_r.idx, rem_red);
          DST_RES:  res_r  <= rem_red;
          default: begin
          end
        endcase
      end
    end
  end

  `LRMP_ASSERT_NEXT(a_accept_starts, in_fire, busy_r && (pc_r == PC_START), "no program start")
  `LRMP_ASSERT_IMP(a_idle_drained, !busy_r, !pipe_busy, "pipeline busy while idle")
  `LRMP_ASSERT_IMP(a_out_drained, busy_r && (ctrl.op == UOP_OUT), !pipe_busy, "early output")
  `LRMP_ASSERT_IMP(a_out_range, out_valid_r, out_data_r < TILE_MOD, "result not reduced")

endmodule

`default_nettype wire

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// Testbench for linear_recurrence_matrix_power_mod
// Sends board widths through the valid/ready input stream and checks every
// tiling count against a square-and-multiply predictor mod 9973. Directed
// widths cover the edge cases, then roughly 830 random widths follow. Both
// sides of the block stall at random.
// ---------------------------------------------------------------------------
import lrmp_pkg::*;

class tiling_scoreboard;
  typedef struct {
    logic [WIDTH_BITS_DEF-1:0] width;
    res_t                      count;
  } pending_t;
  typedef int unsigned wide_t;

  pending_t    pending_counts[$];
  int unsigned fail_count;

  function res_t mod_dot(res_t a, res_t b, res_t c, res_t d);
    wide_t s;
    s = wide_t'(a) * wide_t'(b) + wide_t'(c) * wide_t'(d);
    return res_t'(s % wide_t'(TILE_MOD));
  endfunction

  function mat_t mat_prod(mat_t p, mat_t q);
    mat_t r;
    r.m00 = mod_dot(p.m00, q.m00, p.m01, q.m10);
    r.m01 = mod_dot(p.m00, q.m01, p.m01, q.m11);
    r.m10 = mod_dot(p.m10, q.m00, p.m11, q.m10);
    r.m11 = mod_dot(p.m10, q.m01, p.m11, q.m11);
    return r;
  endfunction

  function res_t count_for_width(logic [WIDTH_BITS_DEF-1:0] n);
    mat_t                      acc;
    mat_t                      pow;
    logic [WIDTH_BITS_DEF-1:0] ex;
    if (n[0]) return RES_ZERO;
    if (n == 0) return RES_ONE;
    if (n == 2) return FINAL_C0;
    ex  = n / 2 - 1;
    acc = MAT_IDENT;
    pow = MAT_BASE_INIT;
    while (ex != 0) begin
      if (ex[0]) acc = mat_prod(acc, pow);
      pow = mat_prod(pow, pow);
      ex  = ex >> 1;
    end
    return mod_dot(FINAL_C0, acc.m00, FINAL_C1, acc.m01);
  endfunction

  function void note_width(logic [WIDTH_BITS_DEF-1:0] w);
    pending_t p;
    p.width = w;
    p.count = count_for_width(w);
    pending_counts.push_back(p);
  endfunction

  function void check_count(res_t got);
    pending_t p;
    if (pending_counts.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: tiling count %0d arrived with no width pending", got);
    end else begin
      p = pending_counts.pop_front();
      if (got !== p.count) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: width %0d: expected count %0d, got %0d", p.width, p.count, got);
      end
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned SETTLE       = 11 * WIDTH_BITS_DEF + 40;

  localparam logic [WIDTH_BITS_DEF-1:0] DIRECTED [22] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd10, 31'd12,
    31'd34, 31'd66, 31'd130, 31'h7FFFFFFF, 31'h7FFFFFFE, 31'h40000000,
    31'h40000002, 31'h2AAAAAAA, 31'h55555554, 31'h55555555, 31'h3FFFFFFE,
    31'h00010000
  };

  logic clk;
  logic rst_n;
  logic steady;
  int unsigned cycle_count;

  tiling_scoreboard book = new();

  lrmp_width_if #(.WIDTH_BITS(WIDTH_BITS_DEF)) in_if ();
  lrmp_count_if out_if ();

  linear_recurrence_matrix_power_mod #(.WIDTH_BITS(WIDTH_BITS_DEF)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_if),
    .out_stream(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly even widths, so most beats exercise the matrix power path.
  function automatic logic [WIDTH_BITS_DEF-1:0] random_width();
    int unsigned               pick;
    int unsigned               len;
    logic [WIDTH_BITS_DEF-1:0] w;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      w = WIDTH_BITS_DEF'($urandom);
    end else if (pick < 7) begin
      w = WIDTH_BITS_DEF'($urandom_range(0, 300));
    end else begin
      len = $urandom_range(1, WIDTH_BITS_DEF);
      w   = WIDTH_BITS_DEF'($urandom & ((32'd1 << len) - 32'd1));
    end
    if ($urandom_range(0, 3) != 0) w[0] = 1'b0;
    return w;
  endfunction

  // Leaves valid high after the beat; the next call either keeps it high or
  // lowers it for a gap, so valid sees one assignment per time step.
  task automatic send_width(input logic [WIDTH_BITS_DEF-1:0] w, input logic no_gaps);
    if (!no_gaps) begin
      if ($urandom_range(0, 99) < 3) begin
        in_if.valid       <= 1'b0;
        in_if.board_width <= WIDTH_BITS_DEF'($urandom);
        repeat ($urandom_range(5, 60)) @(posedge clk);
      end
      while ($urandom_range(0, 99) < 24) begin
        in_if.valid       <= 1'b0;
        in_if.board_width <= WIDTH_BITS_DEF'($urandom);
        @(posedge clk);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.board_width <= w;
    do @(posedge clk); while (!in_if.ready);
    book.note_width(w);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (book.pending_counts.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic run_steady;
    in_if.valid       <= 1'b0;
    in_if.board_width <= '0;
    rst_n             <= 1'b0;
    steady            <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_width(DIRECTED[i], 1'b0);
    drain_results();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      run_steady = (i >= 400 && i < 550);
      steady <= run_steady;
      if (i == 650) drain_results();
      send_width(random_width(), run_steady);
    end
    drain_results();
    repeat (SETTLE) @(posedge clk);

    if (book.pending_counts.size() != 0) begin
      book.fail_count++;
      $display("ERROR: %0d tiling counts never arrived", book.pending_counts.size());
    end
    if (book.fail_count == 0) begin
      $display("linear_recurrence_matrix_power_mod test passed");
    end else begin
      $display("linear_recurrence_matrix_power_mod test failed");
    end
    $finish;
  end

  // Result side: checks the beat seen at this edge, then picks the next ready.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) book.check_count(out_if.tiling_count);
      out_if.ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
    $display("linear_recurrence_matrix_power_mod test failed");
    $finish;
  end
endmodule
